// ----- design/uv_seam_vertex_splitter_core_macros.svh -----
// ---------------------------------------------------------------------------
// uv_seam_vertex_splitter_core_macros
// assertion macros for the uv seam vertex splitter
// ---------------------------------------------------------------------------
`ifndef UV_SEAM_VERTEX_SPLITTER_CORE_MACROS_SVH
`define UV_SEAM_VERTEX_SPLITTER_CORE_MACROS_SVH
`ifndef SYNTH
`define USVS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define USVS_ASSERT_NR(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define USVS_ASSERT(lbl, clk, rst_n, prop, msg)
`define USVS_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

// ----- design/usvs_pkg.sv -----
// ---------------------------------------------------------------------------
// usvs_pkg
// shared types and constants of the uv seam vertex splitter
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package usvs_pkg;
	localparam logic [0:0] CFG_SRC_COUNT = 1'b0;
	localparam logic [0:0] CFG_UV_COUNT = 1'b1;

	typedef struct packed {
		logic [15:0] out_index;
		logic primary_claimed;
		logic vertex_created;
		logic [15:0] created_geom;
		logic [15:0] uv_copy_from;
		logic uv_copy_zero;
		logic overflow;
	} result_t;
endpackage

// ----- design/usvs_ram.sv -----
// ---------------------------------------------------------------------------
// usvs_ram
// generic single port ram with registered read
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module usvs_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

// ----- design/uv_seam_vertex_splitter_core.sv -----
// ---------------------------------------------------------------------------
// uv_seam_vertex_splitter_core
// maps triangle corners to export vertex indices, splitting uv seams
// ---------------------------------------------------------------------------
// One corner is taken while busy is low. A corner whose uv vertex is new, or
// already claimed with the same geometry, or invalid, is resolved without a
// split search. A corner needing one reads the split table one entry at a
// time (read, then compare): at least one entry even while the table is
// empty, at most the fill count otherwise. After reset, busy stays high
// while all UV_DEPTH entries of the primary valid ram are cleared.
// The result strobe lasts one cycle and cannot be stalled.
`timescale 1ns / 1ps
`include "uv_seam_vertex_splitter_core_macros.svh"
module uv_seam_vertex_splitter_core #(
	parameter int unsigned UV_DEPTH = 4096,
	parameter int unsigned SPLIT_DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [16:0] corner_geom,
	input  logic [16:0] corner_uv,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output logic        done,
	output logic [15:0] out_index,
	output logic        primary_claimed,
	output logic        vertex_created,
	output logic [15:0] created_geom,
	output logic [15:0] uv_copy_from,
	output logic        uv_copy_zero,
	output logic        overflow
);
	localparam int unsigned UA = $clog2(UV_DEPTH);
	localparam int unsigned SA = $clog2(SPLIT_DEPTH);
	localparam int unsigned SC = SA + 1;

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_READ, S_DECIDE, S_SREAD, S_SCMP, S_DONE
	} state_t;

	state_t state_q;
	logic [15:0] src_cnt_q;
	logic [12:0] uv_cnt_q;
	logic [16:0] next_q;
	logic [SC-1:0] used_q;
	logic [SC-1:0] idx_q;
	logic [UA-1:0] clr_q;
	logic [15:0] g_q;
	logic [UA-1:0] u_q;
	logic uvok_q;
	usvs_pkg::result_t res_q;
	logic done_q;

	logic p_we;
	logic [UA-1:0] p_addr;
	logic [16:0] p_wdata, p_rdata;
	logic s_we;
	logic [SA-1:0] s_addr;
	logic [UA+31:0] s_wdata, s_rdata;

	logic signed [16:0] gs, us;
	logic [15:0] g_san;
	logic uv_ok;
	assign gs = corner_geom;
	assign us = corner_uv;
	always_comb begin
		g_san = 16'd0;
		if (!gs[16] && gs[15:0] < src_cnt_q) begin
			g_san = gs[15:0];
		end
		uv_ok = !us[16] && ({1'b0, us[15:0]} < {1'b0, 3'd0, uv_cnt_q})
			&& ({1'b0, us[15:0]} < 17'(UV_DEPTH));
	end

	logic [UA-1:0] s_ru;
	logic [15:0] s_rg, s_re;
	assign {s_ru, s_rg, s_re} = s_rdata;

	always_comb begin
		p_we = 1'b0;
		p_addr = u_q;
		p_wdata = {1'b1, g_q};
		s_we = 1'b0;
		s_addr = idx_q[SA-1:0];
		s_wdata = {u_q, g_q, next_q[15:0]};
		case (state_q)
			S_CLEAR: begin
				p_we = 1'b1;
				p_addr = clr_q;
				p_wdata = '0;
			end
			S_IDLE: p_addr = us[UA-1:0];
			S_DECIDE: p_we = uvok_q && !p_rdata[16];
			S_SCMP: s_we = !(idx_q < used_q && s_ru == u_q && s_rg == g_q)
				&& idx_q + 1'b1 >= used_q && used_q < SC'(SPLIT_DEPTH) && !next_q[16];
			default: ;
		endcase
		if (state_q == S_SCMP && idx_q + 1'b1 >= used_q) begin
			s_addr = used_q[SA-1:0];
		end
	end

	usvs_ram #(.WIDTH(17), .DEPTH(UV_DEPTH)) u_prim (
		.clk(clk), .we(p_we), .addr(p_addr), .wdata(p_wdata), .rdata(p_rdata)
	);
	usvs_ram #(.WIDTH(UA + 32), .DEPTH(SPLIT_DEPTH)) u_split (
		.clk(clk), .we(s_we), .addr(s_addr), .wdata(s_wdata), .rdata(s_rdata)
	);

	assign busy = state_q != S_IDLE;
	assign cfg_ready = state_q == S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			src_cnt_q <= '0;
			uv_cnt_q <= '0;
			next_q <= '0;
			used_q <= '0;
			idx_q <= '0;
			clr_q <= '0;
			g_q <= '0;
			u_q <= '0;
			uvok_q <= 1'b0;
			res_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == UA'(UV_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (cfg_valid) begin
						case (cfg_index)
							usvs_pkg::CFG_SRC_COUNT: src_cnt_q <= cfg_data;
							usvs_pkg::CFG_UV_COUNT: begin
								uv_cnt_q <= cfg_data[12:0];
								next_q <= {4'd0, cfg_data[12:0]};
							end
							default: ;
						endcase
					end
					if (start) begin
						g_q <= g_san;
						u_q <= us[UA-1:0];
						uvok_q <= uv_ok;
						state_q <= S_READ;
					end
				end
				S_READ: state_q <= S_DECIDE;
				S_DECIDE: begin
					res_q <= '0;
					idx_q <= '0;
					state_q <= S_DONE;
					if (!uvok_q) begin
						if (next_q[16]) begin
							res_q.overflow <= 1'b1;
						end else begin
							res_q.out_index <= next_q[15:0];
							res_q.vertex_created <= 1'b1;
							res_q.created_geom <= g_q;
							if ({1'b0, g_q} < next_q) begin
								res_q.uv_copy_from <= g_q;
							end else begin
								res_q.uv_copy_zero <= 1'b1;
							end
							next_q <= next_q + 1'b1;
						end
					end else if (!p_rdata[16]) begin
						res_q.out_index <= 16'(u_q);
						res_q.primary_claimed <= 1'b1;
						res_q.created_geom <= g_q;
					end else if (p_rdata[15:0] == g_q) begin
						res_q.out_index <= 16'(u_q);
					end else begin
						state_q <= S_SREAD;
					end
				end
				S_SREAD: state_q <= S_SCMP;
				S_SCMP: begin
					if (idx_q < used_q && s_ru == u_q && s_rg == g_q) begin
						res_q.out_index <= s_re;
						state_q <= S_DONE;
					end else if (idx_q + 1'b1 < used_q) begin
						idx_q <= idx_q + 1'b1;
						state_q <= S_SREAD;
					end else begin
						state_q <= S_DONE;
						if (used_q >= SC'(SPLIT_DEPTH) || next_q[16]) begin
							res_q.overflow <= 1'b1;
						end else begin
							res_q.out_index <= next_q[15:0];
							res_q.vertex_created <= 1'b1;
							res_q.created_geom <= g_q;
							res_q.uv_copy_from <= 16'(u_q);
							next_q <= next_q + 1'b1;
							used_q <= used_q + 1'b1;
						end
					end
				end
				S_DONE: begin
					done_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign out_index = res_q.out_index;
	assign primary_claimed = res_q.primary_claimed;
	assign vertex_created = res_q.vertex_created;
	assign created_geom = res_q.created_geom;
	assign uv_copy_from = res_q.uv_copy_from;
	assign uv_copy_zero = res_q.uv_copy_zero;
	assign overflow = res_q.overflow;

	`USVS_ASSERT(a_used_bound, clk, arst_n, used_q <= SC'(SPLIT_DEPTH), "split count overrun")
	`USVS_ASSERT(a_done_busy, clk, arst_n, done_q |-> !busy, "result while busy")
	`USVS_ASSERT(a_ovf_zero, clk, arst_n, done_q && overflow |-> out_index == 16'd0, "overflow index")
	`USVS_ASSERT(a_one_kind, clk, arst_n, done_q |-> !(primary_claimed && vertex_created), "claim and create")
endmodule
